FILE: rtl/bfa_pkg.sv
// bfa_pkg: shared constants, request codes and interface types
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int NUM_FRAMES_DEF = 65536;
  localparam int MAX_RUN_DEF    = 256;
  localparam int WORD_BITS_DEF  = 64;

  localparam int FRAME_W = 17;
  localparam int IDX_W   = 16;
  localparam int CNT_W   = 9;
  localparam int POS_W   = 18;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_RESERVE = 2'd2;
  localparam logic [1:0] REQ_RELEASE = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [IDX_W-1:0]   frame_index;
    logic [CNT_W-1:0]   page_count;
    logic [FRAME_W-1:0] limit_frame;
  } req_t;

  typedef struct packed {
    logic               req_ok;
    logic [IDX_W-1:0]   result_frame;
    logic [CNT_W-1:0]   double_free_count;
    logic [FRAME_W-1:0] used_count;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [FRAME_W-1:0] eff;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic filling;
  } stat_t;

endpackage

FILE: rtl/bfa_ram.sv
// bfa_ram: generic single write port ram with registered read
`timescale 1ns / 1ps
module bfa_ram #(
  parameter int W = 64,
  parameter int D = 1024,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/bfa_ctrl.sv
// bfa_ctrl: request sequencer walking the frame map word by word
`timescale 1ns / 1ps
module bfa_ctrl #(
  parameter int NUM_FRAMES = 65536,
  parameter int MAX_RUN    = 256,
  parameter int WORD_BITS  = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bfa_pkg::req_t req,
  input  logic [16:0]   eff,
  input  bfa_pkg::cfg_t cfg,
  input  logic          res_ready,
  output logic          res_valid,
  output bfa_pkg::res_t res,
  output bfa_pkg::stat_t st
);
  import bfa_pkg::*;

  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WIDX_W    = $clog2(WORD_BITS);
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);
  localparam logic [FRAME_W-1:0] SS_RST =
    (NUM_FRAMES > 131071) ? 17'd131071 : FRAME_W'(NUM_FRAMES);
  localparam logic [FRAME_W-1:0] USED_RST = FRAME_W'(NUM_FRAMES % 131072);

  localparam logic [2:0] S_FILL = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_CAPT = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [ADDR_W-1:0]    fill_r, fill_nxt;
  logic [POS_W-1:0]     p_r, p_nxt;
  logic [POS_W-1:0]     end_r, end_nxt;
  logic [CNT_W-1:0]     run_r, run_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [FRAME_W-1:0]   maxf_r, maxf_nxt;
  logic [1:0]           op_r, op_nxt;
  logic                 srch_r, srch_nxt;
  logic [WORD_BITS-1:0] buf_r, buf_nxt;
  logic [FRAME_W-1:0]   ss_r, ss_nxt;
  logic [FRAME_W-1:0]   used_r, used_nxt;
  logic                 ok_r, ok_nxt;
  logic [IDX_W-1:0]     res_r, res_nxt;
  logic [CNT_W-1:0]     freed_r, freed_nxt;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  logic [WIDX_W-1:0]    bi;
  logic                 cur;
  logic                 boundary;
  logic [POS_W-1:0]     pos_inc;
  logic [POS_W-1:0]     cand;
  logic                 srch_fail;
  logic [POS_W-1:0]     found_s;
  logic [POS_W-1:0]     rng_end;
  logic [FRAME_W-1:0]   lim_clip;
  logic [ADDR_W-1:0]    p_addr;

  bfa_ram #(.W(WORD_BITS), .D(MAP_WORDS), .AW(ADDR_W)) u_map (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign bi        = p_r[WIDX_W-1:0];
  assign cur       = buf_r[bi];
  assign boundary  = &bi;
  assign pos_inc   = p_r + POS_W'(1);
  assign cand      = p_r - POS_W'(run_r);
  assign srch_fail = (cand + POS_W'(cnt_r)) > POS_W'(maxf_r);
  assign found_s   = pos_inc - POS_W'(cnt_r);
  assign p_addr    = ADDR_W'(p_r >> WIDX_W);
  assign rng_end   = ((POS_W'(req.frame_index) + POS_W'(req.page_count)) < POS_W'(eff)) ?
                     (POS_W'(req.frame_index) + POS_W'(req.page_count)) : POS_W'(eff);
  assign lim_clip  = (req.limit_frame < eff) ? req.limit_frame : eff;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    p_nxt     = p_r;
    end_nxt   = end_r;
    run_nxt   = run_r;
    cnt_nxt   = cnt_r;
    maxf_nxt  = maxf_r;
    op_nxt    = op_r;
    srch_nxt  = srch_r;
    buf_nxt   = buf_r;
    ss_nxt    = ss_r;
    used_nxt  = used_r;
    ok_nxt    = ok_r;
    res_nxt   = res_r;
    freed_nxt = freed_r;
    mem_we    = 1'b0;
    mem_waddr = p_addr;
    mem_wdata = buf_r;
    mem_raddr = p_addr;

    case (state_r)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_r;
        mem_wdata = '1;
        fill_nxt  = fill_r + ADDR_W'(1);
        if (fill_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = req.req_type;
          cnt_nxt   = req.page_count;
          ok_nxt    = 1'b1;
          res_nxt   = '0;
          freed_nxt = '0;
          run_nxt   = '0;
          srch_nxt  = 1'b0;
          if (req.req_type == REQ_ALLOC) begin
            ok_nxt   = 1'b0;
            maxf_nxt = lim_clip;
            p_nxt    = POS_W'(ss_r);
            if (req.page_count == '0 || 32'(req.page_count) > 32'(MAX_RUN)) begin
              state_nxt = S_FIN;
            end else begin
              srch_nxt  = 1'b1;
              state_nxt = S_LOAD;
            end
          end else begin
            if (req.req_type == REQ_FREE && FRAME_W'(req.frame_index) < ss_r) begin
              ss_nxt = FRAME_W'(req.frame_index);
            end
            p_nxt   = POS_W'(req.frame_index);
            end_nxt = rng_end;
            if (POS_W'(req.frame_index) >= rng_end) begin
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_LOAD;
            end
          end
        end
      end
      S_LOAD: begin
        if (srch_r && srch_fail) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CAPT;
        end
      end
      S_CAPT: begin
        buf_nxt   = mem_rdata;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (srch_r) begin
          if (srch_fail) begin
            state_nxt = S_FIN;
          end else if (cur) begin
            run_nxt = '0;
            p_nxt   = pos_inc;
            if (boundary) begin
              state_nxt = S_LOAD;
            end
          end else if (run_r + CNT_W'(1) == cnt_r) begin
            // run found, second pass marks it used
            ok_nxt   = 1'b1;
            res_nxt  = found_s[IDX_W-1:0];
            if (cnt_r == CNT_W'(1) || found_s == POS_W'(ss_r)) begin
              ss_nxt = FRAME_W'(found_s + POS_W'(cnt_r));
            end
            srch_nxt  = 1'b0;
            op_nxt    = REQ_RESERVE;
            p_nxt     = found_s;
            end_nxt   = found_s + POS_W'(cnt_r);
            state_nxt = S_LOAD;
          end else begin
            run_nxt = run_r + CNT_W'(1);
            p_nxt   = pos_inc;
            if (boundary) begin
              state_nxt = S_LOAD;
            end
          end
        end else begin
          if (op_r == REQ_RESERVE) begin
            buf_nxt[bi] = 1'b1;
            if (!cur) begin
              used_nxt = used_r + FRAME_W'(1);
            end
          end else begin
            buf_nxt[bi] = 1'b0;
            if (cur) begin
              used_nxt  = used_r - FRAME_W'(1);
              freed_nxt = freed_r + CNT_W'(1);
              if (op_r == REQ_RELEASE && p_r < POS_W'(ss_r)) begin
                ss_nxt = p_r[FRAME_W-1:0];
              end
            end
          end
          p_nxt = pos_inc;
          if (pos_inc >= end_r || boundary) begin
            mem_we    = 1'b1;
            mem_wdata = buf_nxt;
            state_nxt = (pos_inc >= end_r) ? S_FIN : S_LOAD;
          end
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg.we) begin
      state_nxt = S_FILL;
      fill_nxt  = '0;
      ss_nxt    = cfg.eff;
      used_nxt  = cfg.eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      fill_r  <= '0;
      ss_r    <= SS_RST;
      used_r  <= USED_RST;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ss_r    <= ss_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    end_r   <= end_nxt;
    run_r   <= run_nxt;
    cnt_r   <= cnt_nxt;
    maxf_r  <= maxf_nxt;
    op_r    <= op_nxt;
    srch_r  <= srch_nxt;
    buf_r   <= buf_nxt;
    ok_r    <= ok_nxt;
    res_r   <= res_nxt;
    freed_r <= freed_nxt;
  end

  assign res_valid             = (state_r == S_FIN);
  assign res.req_ok            = ok_r;
  assign res.result_frame      = res_r;
  assign res.double_free_count = (op_r == REQ_FREE) ? (cnt_r - freed_r) : '0;
  assign res.used_count        = used_r;
  assign st.idle               = (state_r == S_IDLE);
  assign st.filling            = (state_r == S_FILL);

endmodule

FILE: rtl/bitmap_frame_allocator.sv
// bitmap_frame_allocator: first-fit page frame allocator over a bitmap ram
// a request reads each map word it visits and then steps through that word's frames;
// an allocate walks the search and then the found run, so it visits its words twice
// throughput: one request at a time; in_ready is high only while the controller is idle
// reset: synchronous active low; a fill pass over every map word
// (1024 by default) sets every frame used, also after each cfg_wr_en write
`timescale 1ns / 1ps
module bitmap_frame_allocator #(
  parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
  parameter int MAX_RUN    = bfa_pkg::MAX_RUN_DEF,
  parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_frame_index,
  input  logic [8:0]  in_page_count,
  input  logic [16:0] in_limit_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_req_ok,
  output logic [15:0] out_result_frame,
  output logic [8:0]  out_double_free_count,
  output logic [16:0] out_used_count,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data
);
  import bfa_pkg::*;

  localparam logic [FRAME_W-1:0] EFF_RST =
    (NUM_FRAMES < 65536) ? FRAME_W'(NUM_FRAMES) : 17'd65536;

  logic [FRAME_W-1:0] eff_r, eff_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_r;
  req_t               req;
  res_t               res;
  cfg_t               cfg;
  stat_t              st;
  logic               start;
  logic               res_valid;
  logic               res_ready;

  assign eff_nxt = (32'(cfg_wr_data) < 32'(NUM_FRAMES)) ? cfg_wr_data : FRAME_W'(NUM_FRAMES);
  assign cfg.we  = cfg_wr_en;
  assign cfg.eff = eff_nxt;

  assign req.req_type    = in_req_type;
  assign req.frame_index = in_frame_index;
  assign req.page_count  = in_page_count;
  assign req.limit_frame = in_limit_frame;

  assign in_ready  = st.idle;
  assign start     = in_valid && in_ready;
  assign res_ready = !out_valid_r || out_ready;

  bfa_ctrl #(
    .NUM_FRAMES (NUM_FRAMES),
    .MAX_RUN    (MAX_RUN),
    .WORD_BITS  (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .eff       (eff_r),
    .cfg       (cfg),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .st        (st)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r       <= EFF_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        eff_r <= eff_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_req_ok            = out_r.req_ok;
  assign out_result_frame      = out_r.result_frame;
  assign out_double_free_count = out_r.double_free_count;
  assign out_used_count        = out_r.used_count;

`ifndef ASSERT_OFF
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !cfg_wr_en |=> !in_ready)
    else $error("input taken while a request is in progress");

  a_fill_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> st.filling && !in_ready)
    else $error("map fill did not start after frame count write");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid_r)
    else $error("finished result not moved to the output register");

  a_no_start_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    st.filling |-> !in_ready)
    else $error("input ready during map fill");
`endif

endmodule

FILE: bench/bfa_checker.sv
// bfa_checker: frame allocator predictor and result scoreboard
`timescale 1ns / 1ps
module bfa_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_frame_index,
  input  logic [8:0]  in_page_count,
  input  logic [16:0] in_limit_frame,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_req_ok,
  input  logic [15:0] out_result_frame,
  input  logic [8:0]  out_double_free_count,
  input  logic [16:0] out_used_count,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  output int          fail_count,
  output int          pending
);
  import bfa_pkg::*;

  localparam int NFR = NUM_FRAMES_DEF;

  bit   used_map [NFR];
  int   hint;
  int   used_frames;
  int   managed;
  res_t answers [$];

  assign pending = answers.size();

  function automatic void mark_all(int eff);
    foreach (used_map[i]) used_map[i] = 1'b1;
    managed = eff;
    used_frames = eff;
    hint = eff;
  endfunction

  function automatic res_t serve(req_t r);
    res_t o;
    int   maxf, i, run, k, idx, last;
    o = '0;
    o.req_ok = 1'b1;
    if (r.req_type == REQ_ALLOC) begin
      o.req_ok = 1'b0;
      maxf = (r.limit_frame < managed) ? r.limit_frame : managed;
      if (r.page_count != 0 && r.page_count <= MAX_RUN_DEF) begin
        i = hint;
        while (i + r.page_count <= maxf) begin
          if (used_map[i]) begin
            i++;
            continue;
          end
          run = 1;
          while (run < r.page_count && !used_map[i + run]) run++;
          if (run < r.page_count) begin
            i += run + 1;
            continue;
          end
          for (k = 0; k < r.page_count; k++) used_map[i + k] = 1'b1;
          used_frames += r.page_count;
          if (r.page_count == 1 || i == hint) hint = i + r.page_count;
          o.req_ok = 1'b1;
          o.result_frame = i[15:0];
          break;
        end
      end
    end else if (r.req_type == REQ_FREE) begin
      for (k = 0; k < r.page_count; k++) begin
        idx = r.frame_index + k;
        if (idx >= managed || !used_map[idx]) begin
          o.double_free_count++;
        end else begin
          used_map[idx] = 1'b0;
          used_frames--;
        end
      end
      if (r.frame_index < hint) hint = r.frame_index;
    end else begin
      last = r.frame_index + r.page_count;
      if (last > managed) last = managed;
      for (idx = r.frame_index; idx < last; idx++) begin
        if (r.req_type == REQ_RESERVE && !used_map[idx]) begin
          used_map[idx] = 1'b1;
          used_frames++;
        end else if (r.req_type == REQ_RELEASE && used_map[idx]) begin
          used_map[idx] = 1'b0;
          used_frames--;
          if (idx < hint) hint = idx;
        end
      end
    end
    o.used_count = used_frames[16:0];
    return o;
  endfunction

  initial begin
    fail_count = 0;
    mark_all(NFR);
  end

  always @(posedge clk) begin
    req_t r;
    res_t e;
    if (!rst_n) begin
      mark_all(NFR);
      answers.delete();
    end else begin
      if (cfg_wr_en)
        mark_all((cfg_wr_data < NFR) ? cfg_wr_data : NFR);
      if (in_valid && in_ready) begin
        r = '{in_req_type, in_frame_index, in_page_count, in_limit_frame};
        answers.push_back(serve(r));
      end
      if (out_valid && out_ready) begin
        if (answers.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          e = answers.pop_front();
          if (out_req_ok !== e.req_ok) begin
            $error("req_ok exp %0d got %0d", e.req_ok, out_req_ok);
            fail_count++;
          end
          if (out_result_frame !== e.result_frame) begin
            $error("result_frame exp %0d got %0d", e.result_frame, out_result_frame);
            fail_count++;
          end
          if (out_double_free_count !== e.double_free_count) begin
            $error("double_free_count exp %0d got %0d", e.double_free_count,
                   out_double_free_count);
            fail_count++;
          end
          if (out_used_count !== e.used_count) begin
            $error("used_count exp %0d got %0d", e.used_count, out_used_count);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

FILE: bench/tb.sv
// tb: stimulus and verdict for the bitmap frame allocator
`timescale 1ns / 1ps
module tb;
  import bfa_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_req_type;
  logic [15:0] in_frame_index;
  logic [8:0]  in_page_count;
  logic [16:0] in_limit_frame;
  logic        out_valid, out_ready;
  logic        out_req_ok;
  logic [15:0] out_result_frame;
  logic [8:0]  out_double_free_count;
  logic [16:0] out_used_count;
  logic        cfg_wr_en;
  logic [16:0] cfg_wr_data;
  int          fail_count, pending;
  int          send_idle, recv_idle;
  int          hold_off;
  longint      cycles;
  int          managed;

  bitmap_frame_allocator dut (.*);

  bfa_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 64'd2_000_000_000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver: random stall plus an optional long hold-off
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send(input logic [1:0] t, input int fi, input int pc, input int lf);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_valid       <= 1'b1;
    in_req_type    <= t;
    in_frame_index <= fi[15:0];
    in_page_count  <= pc[8:0];
    in_limit_frame <= lf[16:0];
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (3 * 1024 + 2000) @(posedge clk);
  endtask

  task automatic set_frames(input int n);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n[16:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    managed = (n < 65536) ? n : 65536;
    repeat (1100) @(posedge clk);
  endtask

  task automatic random_req();
    int sel, base, span;
    sel = $urandom_range(99);
    span = (managed > 0) ? managed : 1;
    base = (managed > 600) ? $urandom_range(managed - 1) % 600 : $urandom_range(span);
    if ($urandom_range(19) == 0) base = $urandom_range(65535);
    if (sel < 40)
      send(REQ_ALLOC, $urandom_range(65535),
           ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 12),
           ($urandom_range(4) == 0) ? $urandom_range(131071) % 65537 : managed);
    else if (sel < 65)
      send(REQ_FREE, base, ($urandom_range(9) == 0) ? $urandom_range(511)
           : $urandom_range(8), 0);
    else if (sel < 80)
      send(REQ_RESERVE, base, ($urandom_range(9) == 0) ? $urandom_range(511)
           : $urandom_range(16), $urandom_range(131071));
    else
      send(REQ_RELEASE, base, ($urandom_range(9) == 0) ? $urandom_range(511)
           : $urandom_range(64), $urandom_range(131071));
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_req_type = 0; in_frame_index = 0; in_page_count = 0;
    in_limit_frame = 0; cfg_wr_en = 0; cfg_wr_data = 0;
    send_idle = 0; recv_idle = 0; hold_off = 0; managed = 65536;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (1100) @(posedge clk);

    // directed: everything used after reset
    send(REQ_ALLOC, 0, 1, 65536);
    send(REQ_RELEASE, 0, 300, 0);
    send(REQ_ALLOC, 65535, 0, 65536);
    send(REQ_ALLOC, 0, 257, 65536);
    send(REQ_ALLOC, 0, 256, 65536);
    send(REQ_ALLOC, 0, 1, 131071);
    send(REQ_ALLOC, 0, 3, 2);
    send(REQ_FREE, 10, 5, 0);
    send(REQ_FREE, 65535, 511, 0);
    send(REQ_RESERVE, 65500, 511, 0);
    send(REQ_RELEASE, 65535, 511, 131071);
    send(REQ_ALLOC, 0, 1, 65536);
    send(REQ_ALLOC, 0, 2, 65536);
    send(REQ_RESERVE, 20, 4, 0);
    send(REQ_ALLOC, 0, 8, 100);
    send(REQ_FREE, 0, 511, 0);
    send(REQ_ALLOC, 0, 511, 65536);
    drain();

    set_frames(0);
    send(REQ_RELEASE, 0, 10, 0);
    send(REQ_ALLOC, 0, 1, 65536);
    send(REQ_FREE, 0, 4, 0);
    drain();

    set_frames(131071);
    send(REQ_RELEASE, 65400, 200, 0);
    send(REQ_ALLOC, 0, 100, 65536);
    drain();

    // random phases with varying frame counts
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 32 : (ph == 1) ? 65 : 0;
      recv_idle = (ph == 0) ? 65 : (ph == 1) ? 32 : 0;
      set_frames((ph == 0) ? 700 : (ph == 1) ? 64 + $urandom_range(400) : 65536);
      if (ph == 2) hold_off = 400;
      for (int n = 0; n < 630; n++) begin
        if (n == 0) send(REQ_RELEASE, 0, 511, 0);
        else random_req();
      end
      drain();
    end

    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: sim.f
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/bfa_ctrl.sv
rtl/bitmap_frame_allocator.sv
bench/bfa_checker.sv
bench/tb.sv
